[src/dqu_pkg.sv]
// ----------------------------------------------------------------------------
// dqu_pkg - shared definitions for the double-ended queue unit
// Field widths, request and error codes, and the per-result control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package dqu_pkg;

    localparam int WORD_W    = 32;
    localparam int REQ_W     = 3;
    localparam int OCC_W     = 11;
    localparam int ERR_W     = 2;
    localparam int DEPTH_DEF = 1024;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

    localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

    // how one result is assembled once the ring read data is back
    typedef struct packed {
        logic             byp_front;
        logic             byp_back;
        logic             is_empty;
        logic [ERR_W-1:0] err;
    } t_resp_info;

endpackage

`default_nettype wire

[src/dqu_ctrl.sv]
// ----------------------------------------------------------------------------
// dqu_ctrl - head pointer and word count of the ring
// Decodes one request beat, updates the pointers and issues the ring accesses.
// ----------------------------------------------------------------------------
`default_nettype none

module dqu_ctrl #(
    parameter int DEPTH  = dqu_pkg::DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int CNT_W  = $clog2(DEPTH + 1)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_fire,
    input  wire logic [dqu_pkg::REQ_W-1:0]   i_req_type,
    output logic                             o_we,
    output logic [ADDR_W-1:0]                o_waddr,
    output logic [ADDR_W-1:0]                o_raddr_f,
    output logic [ADDR_W-1:0]                o_raddr_b,
    output logic [CNT_W-1:0]                 o_count,
    output dqu_pkg::t_resp_info              o_info
);

    localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0]  ONE_CNT  = CNT_W'(1);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W:0]   SUM_LIM  = (ADDR_W + 1)'(DEPTH);

    logic [ADDR_W-1:0] r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  tail_cnt;
    logic [ADDR_W-1:0] tail_off;
    logic              full;
    logic              empty;

    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                   input logic [ADDR_W-1:0] b);
        logic [ADDR_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= SUM_LIM) begin
            sum = sum - SUM_LIM;
        end
        return sum[ADDR_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_fire) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_comb begin
        full             = (r_count == FULL_CNT);
        empty            = (r_count == '0);
        n_head           = r_head;
        n_count          = r_count;
        o_we             = 1'b0;
        o_waddr          = r_head;
        o_info.byp_front = 1'b0;
        o_info.byp_back  = 1'b0;
        o_info.err       = dqu_pkg::ERR_OK;
        case (i_req_type)
            dqu_pkg::REQ_PUSH_FRONT: begin
                if (full) begin
                    o_info.err = dqu_pkg::ERR_FULL;
                end else begin
                    n_head           = (r_head == '0) ? LAST_IDX : r_head - ADDR_W'(1);
                    n_count          = r_count + ONE_CNT;
                    o_we             = 1'b1;
                    o_waddr          = n_head;
                    o_info.byp_front = 1'b1;
                    o_info.byp_back  = empty;
                end
            end
            dqu_pkg::REQ_PUSH_BACK: begin
                if (full) begin
                    o_info.err = dqu_pkg::ERR_FULL;
                end else begin
                    n_count          = r_count + ONE_CNT;
                    o_we             = 1'b1;
                    o_waddr          = wrap_add(r_head, r_count[ADDR_W-1:0]);
                    o_info.byp_back  = 1'b1;
                    o_info.byp_front = empty;
                end
            end
            dqu_pkg::REQ_POP_FRONT: begin
                if (empty) begin
                    o_info.err = dqu_pkg::ERR_EMPTY;
                end else begin
                    n_head  = (r_head == LAST_IDX) ? '0 : r_head + ADDR_W'(1);
                    n_count = r_count - ONE_CNT;
                end
            end
            dqu_pkg::REQ_POP_BACK: begin
                if (empty) begin
                    o_info.err = dqu_pkg::ERR_EMPTY;
                end else begin
                    n_count = r_count - ONE_CNT;
                end
            end
            default: begin
            end
        endcase
        o_info.is_empty = (n_count == '0);
        // back entry sits count-1 places after the head
        tail_cnt  = o_info.is_empty ? '0 : n_count - ONE_CNT;
        tail_off  = tail_cnt[ADDR_W-1:0];
        o_raddr_f = n_head;
        o_raddr_b = wrap_add(n_head, tail_off);
        o_count   = n_count;
    end

endmodule

`default_nettype wire

[src/dqu_ring.sv]
// ----------------------------------------------------------------------------
// dqu_ring - ring store of the queue
// One write port and two registered read ports, read data held between reads.
// ----------------------------------------------------------------------------
`default_nettype none

module dqu_ring #(
    parameter int DEPTH  = dqu_pkg::DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [ADDR_W-1:0]          i_waddr,
    input  wire logic [dqu_pkg::WORD_W-1:0] i_wdata,
    input  wire logic                       i_re,
    input  wire logic [ADDR_W-1:0]          i_raddr_f,
    input  wire logic [ADDR_W-1:0]          i_raddr_b,
    output logic [dqu_pkg::WORD_W-1:0]      o_rdata_f,
    output logic [dqu_pkg::WORD_W-1:0]      o_rdata_b
);

    logic [dqu_pkg::WORD_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // old data on a same-cycle write; the pushed word is bypassed outside
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_f <= r_mem[i_raddr_f];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

[src/double_ended_queue_unit.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_unit - double-ended queue of signed 32-bit words
// Request channel: i_valid / o_stall with i_req_type and i_item_value.
// Result channel: o_valid / i_stall with front, back, occupancy, empty flag
// and error code, all as seen after the request. Every request beat gives
// exactly one result beat, in order.
// A request goes through the read stage and then the result register.
// Throughput: one request per cycle while results are taken, set by the
// single pass through the pointer logic and one write plus two reads
// of the ring memory per cycle.
// A push on a full ring or a pop on an empty one is refused and flagged;
// the pointers stay put.
// Reset clears the head pointer and word count, so the queue starts empty;
// the ring contents need no clearing and requests are taken right away.
// When the receiver stalls, the result register holds and, if the read
// stage is empty, one more request is taken into it; after that o_stall
// rises until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_unit #(
    parameter int DEPTH = dqu_pkg::DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [dqu_pkg::REQ_W-1:0]         i_req_type,
    input  wire logic signed [dqu_pkg::WORD_W-1:0] i_item_value,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic signed [dqu_pkg::WORD_W-1:0]      o_front_value,
    output logic signed [dqu_pkg::WORD_W-1:0]      o_back_value,
    output logic [dqu_pkg::OCC_W-1:0]              o_occupancy,
    output logic                                   o_is_empty,
    output logic [dqu_pkg::ERR_W-1:0]              o_error_code
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    logic                       fire;
    logic                       b_free;
    logic                       a_move;
    logic                       we;
    logic [ADDR_W-1:0]          waddr;
    logic [ADDR_W-1:0]          raddr_f;
    logic [ADDR_W-1:0]          raddr_b;
    logic [CNT_W-1:0]           count;
    dqu_pkg::t_resp_info        info;
    logic [dqu_pkg::WORD_W-1:0] rdata_f;
    logic [dqu_pkg::WORD_W-1:0] rdata_b;

    // read stage
    logic                       r_a_valid;
    dqu_pkg::t_resp_info        r_a_info;
    logic [dqu_pkg::WORD_W-1:0] r_a_word;
    logic [CNT_W-1:0]           r_a_count;

    // result register
    logic                              r_b_valid;
    logic signed [dqu_pkg::WORD_W-1:0] r_b_front;
    logic signed [dqu_pkg::WORD_W-1:0] r_b_back;
    logic [dqu_pkg::OCC_W-1:0]         r_b_occ;
    logic                              r_b_empty;
    logic [dqu_pkg::ERR_W-1:0]         r_b_err;

    assign b_free  = !r_b_valid || !i_stall;
    assign a_move  = r_a_valid && b_free;
    assign o_stall = r_a_valid && !b_free;
    assign fire    = i_valid && !o_stall;

    dqu_ctrl #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_req_type (i_req_type),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_raddr_f  (raddr_f),
        .o_raddr_b  (raddr_b),
        .o_count    (count),
        .o_info     (info)
    );

    dqu_ring #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_we      (we && fire),
        .i_waddr   (waddr),
        .i_wdata   (i_item_value),
        .i_re      (fire),
        .i_raddr_f (raddr_f),
        .i_raddr_b (raddr_b),
        .o_rdata_f (rdata_f),
        .o_rdata_b (rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (fire) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_a_info  <= info;
            r_a_word  <= i_item_value;
            r_a_count <= count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_move) begin
            r_b_valid <= 1'b1;
        end else if (!i_stall) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            if (r_a_info.is_empty) begin
                r_b_front <= dqu_pkg::EMPTY_WORD;
                r_b_back  <= dqu_pkg::EMPTY_WORD;
            end else begin
                r_b_front <= r_a_info.byp_front ? r_a_word : rdata_f;
                r_b_back  <= r_a_info.byp_back ? r_a_word : rdata_b;
            end
            r_b_occ   <= dqu_pkg::OCC_W'(r_a_count);
            r_b_empty <= r_a_info.is_empty;
            r_b_err   <= r_a_info.err;
        end
    end

    assign o_valid       = r_b_valid;
    assign o_front_value = r_b_front;
    assign o_back_value  = r_b_back;
    assign o_occupancy   = r_b_occ;
    assign o_is_empty    = r_b_empty;
    assign o_error_code  = r_b_err;

endmodule

`default_nettype wire
